### rtl/sabt_pkg.sv
package sabt_pkg;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_FAST_SPEED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAST_RATE      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_SPEED     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_RATE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_MIN_ANGLE = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_SLOPE     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_HOLDOFF   = 3'd6;

    // Register reset values
    localparam logic [11:0] FAST_SPEED_RST     = 12'd1440;
    localparam logic [15:0] FAST_RATE_RST      = 16'd60;
    localparam logic [11:0] SLOW_SPEED_RST     = 12'd80;
    localparam logic [15:0] SLOW_RATE_RST      = 16'd1200;
    localparam logic [7:0]  TURN_MIN_ANGLE_RST = 8'd28;
    localparam logic [15:0] TURN_SLOPE_RST     = 16'd255;
    localparam logic [15:0] TURN_HOLDOFF_RST   = 16'd5;

    // Arithmetic constants
    localparam logic [11:0] MS_PER_SEC  = 12'd1000;
    localparam logic [12:0] COURSE_HALF = 13'd2880;
    localparam logic [14:0] COURSE_FULL = 15'd5760;

    // ms to whole seconds: floor(x / 1000) = ((x >> 3) * ceil(2^36 / 125)) >> 36,
    // exact for every 32-bit x
    localparam logic [29:0] SEC_RECIP = 30'd549755814;

    // Divider
    localparam int DIV_STEP_W = 6;
    localparam logic [DIV_STEP_W-1:0] DIV_STEPS_INTERVAL = 6'd28;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [11:0] speed;
        logic [12:0] course;
    } req_t;

    typedef struct packed {
        logic        send_beacon;
        logic [22:0] seconds_since_last;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic item_load;
        logic prep_load;
        logic div_start;
        logic elapsed_load;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic skip;
        logic no_div;
    } sts_t;

endpackage

### rtl/sabt_if.sv
// Request channel
interface sabt_req_if import sabt_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface sabt_rsp_if import sabt_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/sabt_div.sv
module sabt_div import sabt_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           dividend,
    input  logic [11:0]           divisor,
    input  logic [DIV_STEP_W-1:0] steps,
    output logic                  busy,
    output logic [31:0]           quotient
);

    logic [11:0]           rem_reg, rem_next;
    logic [31:0]           quo_reg, quo_next;
    logic [11:0]           dsr_reg, dsr_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;

    logic [12:0] shifted;
    logic [12:0] diff;
    logic        ge;

    // One restoring step per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = shifted >= {1'b0, dsr_reg};

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[11:0] : shifted[11:0];
            quo_next  = {quo_reg[30:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/sabt_datapath.sv
module sabt_datapath import sabt_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  req_t                   item,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output rsp_t                   result
);

    // Configuration
    logic [11:0] fast_speed_reg;
    logic [15:0] fast_rate_reg;
    logic [11:0] slow_speed_reg;
    logic [15:0] slow_rate_reg;
    logic [7:0]  turn_min_angle_reg;
    logic [15:0] turn_slope_reg;
    logic [15:0] turn_holdoff_reg;

    // Beacon state
    logic        first_fix_reg, first_fix_next;
    logic [12:0] last_course_reg, last_course_next;
    logic [31:0] last_beacon_reg, last_beacon_next;
    logic [31:0] last_turn_reg, last_turn_next;

    // Item and intermediate values
    req_t        item_reg;
    logic        low_reg, high_reg;
    logic [11:0] dspd_reg;
    logic [11:0] den_reg;
    logic        rneg_reg;
    logic [15:0] rmag_reg;
    logic        kneg_reg;
    logic [11:0] kp1_reg;
    logic [28:0] eb_reg;
    logic [58:0] sec_prod_reg;
    logic [27:0] prod_i_reg;
    logic [23:0] turn_prod_reg;
    logic [25:0] hold_ms_reg;
    logic [22:0] elapsed_reg;
    rsp_t        result_reg;

    logic [31:0] diff_b, diff_t;
    logic [12:0] dabs;
    logic [14:0] dfold, k;
    logic        div_busy;
    logic [31:0] div_quo;
    logic [15:0] interval;
    logic        interval_hit, turn_hit;
    logic        send;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_speed_reg     <= FAST_SPEED_RST;
            fast_rate_reg      <= FAST_RATE_RST;
            slow_speed_reg     <= SLOW_SPEED_RST;
            slow_rate_reg      <= SLOW_RATE_RST;
            turn_min_angle_reg <= TURN_MIN_ANGLE_RST;
            turn_slope_reg     <= TURN_SLOPE_RST;
            turn_holdoff_reg   <= TURN_HOLDOFF_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAST_SPEED:     fast_speed_reg     <= cfg_data[11:0];
                REG_FAST_RATE:      fast_rate_reg      <= cfg_data;
                REG_SLOW_SPEED:     slow_speed_reg     <= cfg_data[11:0];
                REG_SLOW_RATE:      slow_rate_reg      <= cfg_data;
                REG_TURN_MIN_ANGLE: turn_min_angle_reg <= cfg_data[7:0];
                REG_TURN_SLOPE:     turn_slope_reg     <= cfg_data;
                REG_TURN_HOLDOFF:   turn_holdoff_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Elapsed times since last beacon and last turn beacon, mod 2^32
    assign diff_b = item_reg.now_ms - last_beacon_reg;
    assign diff_t = item_reg.now_ms - last_turn_reg;

    // Folded course change minus the fixed part of the threshold
    always_comb
    begin
        dabs  = (item_reg.course >= last_course_reg) ? item_reg.course - last_course_reg
                                                     : last_course_reg - item_reg.course;
        dfold = (dabs > COURSE_HALF) ? COURSE_FULL - {2'b00, dabs} : {2'b00, dabs};
        k     = dfold - {3'b000, turn_min_angle_reg, 4'b0000};
    end

    // Item capture and per-item preparation
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
            item_reg <= item;
        if (cmd.prep_load)
        begin
            low_reg  <= item_reg.speed <= slow_speed_reg;
            high_reg <= item_reg.speed >= fast_speed_reg;
            dspd_reg <= item_reg.speed - slow_speed_reg;
            den_reg  <= fast_speed_reg - slow_speed_reg;
            rneg_reg <= slow_rate_reg < fast_rate_reg;
            rmag_reg <= (slow_rate_reg >= fast_rate_reg) ? slow_rate_reg - fast_rate_reg
                                                         : fast_rate_reg - slow_rate_reg;
            kneg_reg <= k[14];
            kp1_reg  <= k[11:0] + 12'd1;
            eb_reg   <= diff_b[31:3];
        end
        if (cmd.elapsed_load)
            elapsed_reg <= sec_prod_reg[58:36];
        if (cmd.finish)
            result_reg <= '{send_beacon: send, seconds_since_last: elapsed_reg};
    end

    // Products, one register after each multiplier
    always_ff @(posedge clk)
    begin
        sec_prod_reg  <= eb_reg * SEC_RECIP;
        prod_i_reg    <= dspd_reg * rmag_reg;
        turn_prod_reg <= kp1_reg * item_reg.speed;
        hold_ms_reg   <= turn_holdoff_reg * MS_PER_SEC[9:0];
    end

    // Iterative divider for the interpolation quotient
    sabt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({prod_i_reg, 4'b0000}),
        .divisor  (den_reg),
        .steps    (DIV_STEPS_INTERVAL),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Beacon decision
    always_comb
    begin
        if (low_reg)
            interval = slow_rate_reg;
        else if (high_reg)
            interval = fast_rate_reg;
        else if (rneg_reg)
            interval = slow_rate_reg + div_quo[15:0];
        else
            interval = slow_rate_reg - div_quo[15:0];

        interval_hit = elapsed_reg >= {7'd0, interval};
        turn_hit     = !low_reg && !kneg_reg
                       && (turn_prod_reg > {turn_slope_reg, 8'h00})
                       && (diff_t >= {6'd0, hold_ms_reg});

        send             = 1'b0;
        first_fix_next   = first_fix_reg;
        last_course_next = last_course_reg;
        last_beacon_next = last_beacon_reg;
        last_turn_next   = last_turn_reg;

        if (item_reg.func)
        begin
            first_fix_next   = 1'b0;
            last_beacon_next = item_reg.now_ms;
        end
        else if (first_fix_reg)
        begin
            send             = 1'b1;
            first_fix_next   = 1'b0;
            last_course_next = item_reg.course;
            last_beacon_next = item_reg.now_ms;
            last_turn_next   = item_reg.now_ms;
        end
        else if (interval_hit)
        begin
            send             = 1'b1;
            last_course_next = item_reg.course;
            last_beacon_next = item_reg.now_ms;
        end
        else if (turn_hit)
        begin
            send             = 1'b1;
            last_course_next = item_reg.course;
            last_beacon_next = item_reg.now_ms;
            last_turn_next   = item_reg.now_ms;
        end
    end

    // Beacon state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_fix_reg   <= 1'b1;
            last_course_reg <= '0;
            last_beacon_reg <= '0;
            last_turn_reg   <= '0;
        end
        else if (cmd.finish)
        begin
            first_fix_reg   <= first_fix_next;
            last_course_reg <= last_course_next;
            last_beacon_reg <= last_beacon_next;
            last_turn_reg   <= last_turn_next;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.skip     = item_reg.func | first_fix_reg;
    assign sts.no_div   = low_reg | high_reg;
    assign result       = result_reg;

endmodule

### rtl/sabt_ctrl.sv
module sabt_ctrl import sabt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_START  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_ISTART = 3'd3;
    localparam logic [2:0] S_IWAIT  = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.item_load = 1'b1;
                    state_next    = S_START;
                end
            end
            S_START:
            begin
                cmd.prep_load = 1'b1;
                state_next    = S_MUL;
            end
            // Products settle
            S_MUL:
                state_next = S_ISTART;
            S_ISTART:
            begin
                cmd.elapsed_load = 1'b1;
                if (sts.skip || sts.no_div)
                    state_next = S_FIN;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_IWAIT;
                end
            end
            S_IWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Result valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

### rtl/speed_adaptive_beacon_timer_top.sv
// Restarts, first fixes and speeds outside the interpolation band skip the divider;
// an interpolated interval also waits for the one-bit-per-cycle divider
// (28 steps for the interpolation quotient). A new request is taken only after the
// previous one has finished; seconds come from a reciprocal multiply.
// A result still held by the receiver stalls the next one in its last cycle.
// Reset (async, active low) loads the default register values and arms first fix.
module speed_adaptive_beacon_timer_top import sabt_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    sabt_req_if.sink               req,
    sabt_rsp_if.source             rsp
);

    cmd_t cmd;
    sts_t sts;
    logic req_ready;
    logic rsp_valid;

    sabt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sabt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (rsp.data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;

endmodule
